### rtl/core/bba_pkg.sv
`timescale 1ns / 1ps
// Package for the buddy block allocator: sizes, codes, the result word
// type and the bit helpers for the free-tree memory. Depends on nothing.
package bba_pkg;

   localparam int MIN_ORDER   = 5;
   localparam int MAX_ORDER   = 16;
   localparam int TREE_LEVELS = MAX_ORDER - MIN_ORDER;
   localparam int LEAF_COUNT  = 1 << TREE_LEVELS;
   localparam int NODE_COUNT  = 2 << TREE_LEVELS;
   localparam int DATA_W      = 16;
   localparam int ORDER_W     = 5;
   localparam int STATUS_W    = 2;
   localparam int LVL_W       = $clog2(TREE_LEVELS + 1);
   localparam int NODE_W      = $clog2(NODE_COUNT);
   localparam int LEAF_W      = TREE_LEVELS;
   localparam int WORD_BITS   = 64;
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int TREE_WORDS  = NODE_COUNT / WORD_BITS;
   localparam int WADDR_W     = $clog2(TREE_WORDS);
   localparam int TAG_W       = 4;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_MEM   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   addr;
      logic [ORDER_W-1:0]  block_order;
   } res_type;

   // Bits of one tree word whose node indexes sit on the given level.
   function automatic logic [WORD_BITS-1:0] level_mask(input logic [WADDR_W-1:0] w,
                                                       input logic [LVL_W-1:0] lvl);
      logic [WORD_BITS-1:0] m;
      logic [NODE_W-1:0]    n;
      m = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         n = {w, BIT_W'(b)};
         m[b] = ((n >> lvl) == NODE_W'(1));
      end
      return m;
   endfunction

   function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] m);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (m[i]) idx = BIT_W'(i);
      end
      return idx;
   endfunction

   // Smallest order whose block holds size plus one header byte.
   function automatic logic [ORDER_W-1:0] size_order(input logic [DATA_W-1:0] size);
      logic [ORDER_W-1:0] o;
      o = '0;
      for (int i = 0; i < DATA_W; i++) begin
         if (size[i]) o = ORDER_W'(i + 1);
      end
      if (o < ORDER_W'(MIN_ORDER)) o = ORDER_W'(MIN_ORDER);
      return o;
   endfunction

endpackage

### rtl/core/bba_req_if.sv
`timescale 1ns / 1ps
// Request channel of the buddy block allocator.
// Depends on bba_pkg.
interface bba_req_if;
   import bba_pkg::*;
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [DATA_W-1:0] req_size;
   logic [DATA_W-1:0] free_addr;
   modport source(output valid, req_type, req_size, free_addr, input ready);
   modport sink(input valid, req_type, req_size, free_addr, output ready);
endinterface

### rtl/core/bba_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the buddy block allocator.
// Depends on bba_pkg.
interface bba_rsp_if;
   import bba_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   addr;
   logic [ORDER_W-1:0]  block_order;
   modport source(output valid, status, addr, block_order, input ready);
   modport sink(input valid, status, addr, block_order, output ready);
endinterface

### rtl/core/bba_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/core/bba_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the buddy block allocator: clearing sweep, level scan, split
// and merge over the free-tree and tag memories. Depends on bba_pkg, bba_req_if.
module bba_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   bba_req_if.sink                         req_chan,
   output logic                            res_valid,
   input  logic                            res_ready,
   output bba_pkg::res_type                res,
   output logic                            tree_we,
   output logic [bba_pkg::WADDR_W-1:0]     tree_waddr,
   output logic [bba_pkg::WORD_BITS-1:0]   tree_wdata,
   output logic [bba_pkg::WADDR_W-1:0]     tree_raddr,
   input  logic [bba_pkg::WORD_BITS-1:0]   tree_rdata,
   output logic                            tag_we,
   output logic [bba_pkg::LEAF_W-1:0]      tag_waddr,
   output logic [bba_pkg::TAG_W-1:0]       tag_wdata,
   output logic [bba_pkg::LEAF_W-1:0]      tag_raddr,
   input  logic [bba_pkg::TAG_W-1:0]       tag_rdata
);
   import bba_pkg::*;

   typedef enum logic [10:0] {
      S_CLEAR    = 11'b000_0000_0001,
      S_IDLE     = 11'b000_0000_0010,
      S_SCAN_RD  = 11'b000_0000_0100,
      S_SCAN_CHK = 11'b000_0000_1000,
      S_SPLIT_RD = 11'b000_0001_0000,
      S_SPLIT_WR = 11'b000_0010_0000,
      S_TAG      = 11'b000_0100_0000,
      S_FTAG     = 11'b000_1000_0000,
      S_MRG_RD   = 11'b001_0000_0000,
      S_MRG_WR   = 11'b010_0000_0000,
      S_DONE     = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [LEAF_W-1:0]  clr_ff, clr_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic [LVL_W-1:0]   lvln_ff, lvln_in;
   logic [ORDER_W-1:0] order_ff, order_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [WADDR_W-1:0] w_ff, w_in;
   logic [LEAF_W-1:0]  leaf_ff, leaf_in;
   logic [DATA_W-1:0]  addr_ff, addr_in;
   res_type            res_ff, res_in;
   logic [NODE_W-1:0]  cnt_ff [TREE_LEVELS+1];

   logic               cnt_inc, cnt_dec;
   logic [LVL_W-1:0]   cnt_idx;

   logic [DATA_W-1:0]    off;
   logic [ORDER_W-1:0]   ord;
   logic [LVL_W-1:0]     need_lvl, pick_lvl;
   logic                 pick_ok;
   logic [WORD_BITS-1:0] hit;
   logic [BIT_W-1:0]     hit_bit, bud_bit;
   logic [NODE_W-1:0]    diff;
   logic [NODE_W-1:0]    shifted;
   logic [ORDER_W-1:0]   free_ord;
   logic [LVL_W-1:0]     free_lvl;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign res_valid      = (state_ff == S_DONE);
   assign res            = res_ff;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      lvl_in    = lvl_ff;
      lvln_in   = lvln_ff;
      order_in  = order_ff;
      node_in   = node_ff;
      w_in      = w_ff;
      leaf_in   = leaf_ff;
      addr_in   = addr_ff;
      res_in    = res_ff;
      cnt_inc   = 1'b0;
      cnt_dec   = 1'b0;
      cnt_idx   = lvl_ff;
      tree_we    = 1'b0;
      tree_waddr = '0;
      tree_wdata = '0;
      tree_raddr = '0;
      tag_we     = 1'b0;
      tag_waddr  = '0;
      tag_wdata  = '0;
      tag_raddr  = '0;

      off      = req_chan.free_addr - DATA_W'(1);
      ord      = size_order(req_chan.req_size);
      need_lvl = LVL_W'(ORDER_W'(MAX_ORDER) - ord);
      pick_lvl = '0;
      pick_ok  = 1'b0;
      for (int i = 0; i <= TREE_LEVELS; i++) begin
         if (LVL_W'(i) <= need_lvl && cnt_ff[i] != '0) begin
            pick_lvl = LVL_W'(i);
            pick_ok  = 1'b1;
         end
      end
      hit      = tree_rdata & level_mask(w_ff, lvl_ff);
      hit_bit  = lowest_bit(hit);
      bud_bit  = node_ff[BIT_W-1:0] ^ BIT_W'(1);
      diff     = node_ff - (NODE_W'(1) << lvl_ff);
      shifted  = diff << (LVL_W'(TREE_LEVELS) - lvl_ff);
      free_ord = ORDER_W'(tag_rdata) + ORDER_W'(MIN_ORDER - 1);
      free_lvl = LVL_W'(ORDER_W'(MAX_ORDER) - free_ord);

      unique case (state_ff)
         S_CLEAR: begin
            tag_we    = 1'b1;
            tag_waddr = clr_ff;
            if (clr_ff < LEAF_W'(TREE_WORDS)) begin
               tree_we    = 1'b1;
               tree_waddr = clr_ff[WADDR_W-1:0];
               tree_wdata = (clr_ff == '0) ? (WORD_BITS'(1) << 1) : '0;
            end
            clr_in = clr_ff + LEAF_W'(1);
            if (clr_ff == LEAF_W'(LEAF_COUNT - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.req_type == REQ_FREE) begin
                  addr_in = req_chan.free_addr;
                  if (req_chan.free_addr == '0 || off[MIN_ORDER-1:0] != '0 ||
                      (32'(off) >> MAX_ORDER) != 32'd0) begin
                     res_in   = '{ST_BAD_FREE, '0, '0};
                     state_in = S_DONE;
                  end else begin
                     leaf_in   = off[MIN_ORDER +: LEAF_W];
                     tag_raddr = off[MIN_ORDER +: LEAF_W];
                     state_in  = S_FTAG;
                  end
               end else begin
                  if (ord > ORDER_W'(MAX_ORDER) || !pick_ok) begin
                     res_in   = '{ST_NO_MEM, '0, '0};
                     state_in = S_DONE;
                  end else begin
                     order_in = ord;
                     lvln_in  = need_lvl;
                     lvl_in   = pick_lvl;
                     w_in     = WADDR_W'((NODE_W'(1) << pick_lvl) >> BIT_W);
                     state_in = S_SCAN_RD;
                  end
               end
            end
         end
         S_SCAN_RD: begin
            tree_raddr = w_ff;
            state_in   = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (hit != '0) begin
               node_in    = {w_ff, hit_bit};
               tree_we    = 1'b1;
               tree_waddr = w_ff;
               tree_wdata = tree_rdata & ~(WORD_BITS'(1) << hit_bit);
               cnt_dec    = 1'b1;
               state_in   = (lvl_ff == lvln_ff) ? S_TAG : S_SPLIT_RD;
            end else begin
               w_in     = w_ff + WADDR_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_SPLIT_RD: begin
            // The upper child of the node sits in the word of its lower child.
            tree_raddr = node_ff[NODE_W-2 -: WADDR_W];
            state_in   = S_SPLIT_WR;
         end
         S_SPLIT_WR: begin
            tree_we    = 1'b1;
            tree_waddr = node_ff[NODE_W-2 -: WADDR_W];
            tree_wdata = tree_rdata | (WORD_BITS'(1) << {node_ff[BIT_W-2:0], 1'b1});
            node_in    = {node_ff[NODE_W-2:0], 1'b0};
            lvl_in     = lvl_ff + LVL_W'(1);
            cnt_inc    = 1'b1;
            cnt_idx    = lvl_ff + LVL_W'(1);
            state_in   = (lvl_ff + LVL_W'(1) == lvln_ff) ? S_TAG : S_SPLIT_RD;
         end
         S_TAG: begin
            tag_we    = 1'b1;
            tag_waddr = shifted[LEAF_W-1:0];
            tag_wdata = TAG_W'(order_ff - ORDER_W'(MIN_ORDER - 1));
            res_in    = '{ST_OK, {shifted[LEAF_W-1:0], MIN_ORDER'(0)} + DATA_W'(1),
                          order_ff};
            state_in  = S_DONE;
         end
         S_FTAG: begin
            if (tag_rdata == '0) begin
               res_in   = '{ST_BAD_FREE, '0, '0};
               state_in = S_DONE;
            end else begin
               tag_we    = 1'b1;
               tag_waddr = leaf_ff;
               tag_wdata = '0;
               if (free_ord > ORDER_W'(MAX_ORDER)) begin
                  res_in   = '{ST_BAD_FREE, '0, '0};
                  state_in = S_DONE;
               end else begin
                  order_in = free_ord;
                  lvl_in   = free_lvl;
                  node_in  = (NODE_W'(1) << free_lvl) +
                             NODE_W'(leaf_ff >> (tag_rdata - TAG_W'(1)));
                  state_in = S_MRG_RD;
               end
            end
         end
         S_MRG_RD: begin
            tree_raddr = node_ff[NODE_W-1:BIT_W];
            state_in   = S_MRG_WR;
         end
         S_MRG_WR: begin
            tree_we    = 1'b1;
            tree_waddr = node_ff[NODE_W-1:BIT_W];
            // A node and its buddy always share one tree word.
            if (node_ff > NODE_W'(1) && tree_rdata[bud_bit]) begin
               tree_wdata = tree_rdata & ~(WORD_BITS'(1) << bud_bit);
               cnt_dec    = 1'b1;
               node_in    = node_ff >> 1;
               lvl_in     = lvl_ff - LVL_W'(1);
               state_in   = S_MRG_RD;
            end else begin
               tree_wdata = tree_rdata | (WORD_BITS'(1) << node_ff[BIT_W-1:0]);
               cnt_inc    = 1'b1;
               res_in     = '{ST_OK, addr_ff, order_ff};
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         for (int i = 0; i <= TREE_LEVELS; i++)
            cnt_ff[i] <= (i == 0) ? NODE_W'(1) : '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (cnt_inc) cnt_ff[cnt_idx] <= cnt_ff[cnt_idx] + NODE_W'(1);
         else if (cnt_dec) cnt_ff[cnt_idx] <= cnt_ff[cnt_idx] - NODE_W'(1);
      end
      lvl_ff   <= lvl_in;
      lvln_ff  <= lvln_in;
      order_ff <= order_in;
      node_ff  <= node_in;
      w_ff     <= w_in;
      leaf_ff  <= leaf_in;
      addr_ff  <= addr_in;
      res_ff   <= res_in;
   end

   a_root_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] <= NODE_W'(1))
      else $error("root level holds more than one free block");
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !tree_we)
      else $error("tree written while idle");
   a_ok_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_ff.status == ST_OK) |-> res_ff.addr != '0)
      else $error("successful result carries address zero");
   a_split_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPLIT_WR) |-> lvl_ff < lvln_ff)
      else $error("split ran past the needed level");
endmodule

### rtl/core/buddy_block_allocator.sv
`timescale 1ns / 1ps
// Top level of the buddy block allocator: memories, sequencer, result register.
// Depends on bba_pkg, bba_req_if, bba_rsp_if, bba_ram, bba_ctrl.
//
//   channel    dir   word
//   req_chan   in    req_type, req_size, free_addr
//   rsp_chan   out   status, addr, block_order
//
// After reset a sweep clears the tag memory and the free tree; no request is
// taken during it. An allocate scans one level of the tree memory, one 64-node word
// at a time (a read, then a check), then splits down level by level (read, then write).
// A free reads the tag, then merges level by level (read, then write).
// One request is in work at a time; a finished result waits in the output register.
module buddy_block_allocator (
   input logic      clock,
   input logic      reset,
   bba_req_if.sink  req_chan,
   bba_rsp_if.source rsp_chan
);
   import bba_pkg::*;

   logic                 res_valid, res_ready;
   res_type              res;
   logic                 tree_we;
   logic [WADDR_W-1:0]   tree_waddr, tree_raddr;
   logic [WORD_BITS-1:0] tree_wdata, tree_rdata;
   logic                 tag_we;
   logic [LEAF_W-1:0]    tag_waddr, tag_raddr;
   logic [TAG_W-1:0]     tag_wdata, tag_rdata;

   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_ff;

   bba_ram #(.WIDTH(WORD_BITS), .DEPTH(TREE_WORDS)) u_tree (
      .clock(clock), .we(tree_we), .waddr(tree_waddr), .wdata(tree_wdata),
      .raddr(tree_raddr), .rdata(tree_rdata)
   );

   bba_ram #(.WIDTH(TAG_W), .DEPTH(LEAF_COUNT)) u_tag (
      .clock(clock), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
      .raddr(tag_raddr), .rdata(tag_rdata)
   );

   bba_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_chan(req_chan),
      .res_valid(res_valid), .res_ready(res_ready), .res(res),
      .tree_we(tree_we), .tree_waddr(tree_waddr), .tree_wdata(tree_wdata),
      .tree_raddr(tree_raddr), .tree_rdata(tree_rdata),
      .tag_we(tag_we), .tag_waddr(tag_waddr), .tag_wdata(tag_wdata),
      .tag_raddr(tag_raddr), .tag_rdata(tag_rdata)
   );

   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid && res_ready) rsp_ff <= res;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_ff.status;
   assign rsp_chan.addr        = rsp_ff.addr;
   assign rsp_chan.block_order = rsp_ff.block_order;
endmodule

### tb/sv/bba_checker.sv
`timescale 1ns / 1ps
// Checker for the buddy block allocator: tracks the heap state on its own,
// predicts each response word and compares it. Depends on bba_pkg and the channels.
module bba_checker (
   input  logic clock,
   input  logic reset,
   bba_req_if   req,
   bba_rsp_if   rsp,
   output int   mismatches,
   output int   outstanding
);
   import bba_pkg::*;

   logic             heap_free [NODE_COUNT];
   logic [TAG_W-1:0] block_tag [LEAF_COUNT];
   res_type          awaited [$];

   function automatic res_type heap_result(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] a,
                                           logic [ORDER_W-1:0] o);
      res_type r;
      r.status      = st;
      r.addr        = a;
      r.block_order = o;
      return r;
   endfunction

   function automatic res_type allocate_block(logic [DATA_W-1:0] size);
      int ord, o, node, first, off;
      ord = 0;
      while ((1 << ord) < int'(size) + 1) ord++;
      if (ord < MIN_ORDER) ord = MIN_ORDER;
      if (ord > MAX_ORDER) return heap_result(ST_NO_MEM, '0, '0);
      node = 0;
      for (o = ord; o <= MAX_ORDER && node == 0; o++) begin
         first = 1 << (MAX_ORDER - o);
         for (int k = 0; k < first && node == 0; k++)
            if (heap_free[first + k]) node = first + k;
      end
      if (node == 0) return heap_result(ST_NO_MEM, '0, '0);
      o--;
      heap_free[node] = 1'b0;
      // Keep the lower half at each split; the upper half becomes free.
      while (o > ord) begin
         node = 2 * node;
         heap_free[node + 1] = 1'b1;
         o--;
      end
      off = (node - (1 << (MAX_ORDER - ord))) << ord;
      block_tag[off >> MIN_ORDER] = TAG_W'(ord - MIN_ORDER + 1);
      return heap_result(ST_OK, DATA_W'(off + 1), ORDER_W'(ord));
   endfunction

   function automatic res_type release_block(logic [DATA_W-1:0] a);
      int off, leaf, ord, node;
      if (a == '0) return heap_result(ST_BAD_FREE, '0, '0);
      off = int'(a) - 1;
      if ((off % (1 << MIN_ORDER)) != 0) return heap_result(ST_BAD_FREE, '0, '0);
      leaf = off >> MIN_ORDER;
      if (block_tag[leaf] == '0) return heap_result(ST_BAD_FREE, '0, '0);
      ord = int'(block_tag[leaf]) + MIN_ORDER - 1;
      block_tag[leaf] = '0;
      if (ord > MAX_ORDER) return heap_result(ST_BAD_FREE, '0, '0);
      node = (1 << (MAX_ORDER - ord)) + (off >> ord);
      heap_free[node] = 1'b1;
      while (node > 1 && heap_free[node ^ 1]) begin
         heap_free[node]     = 1'b0;
         heap_free[node ^ 1] = 1'b0;
         node = node >> 1;
         heap_free[node] = 1'b1;
      end
      return heap_result(ST_OK, a, ORDER_W'(ord));
   endfunction

   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         for (int n = 0; n < NODE_COUNT; n++) heap_free[n] = 1'b0;
         for (int l = 0; l < LEAF_COUNT; l++) block_tag[l] = '0;
         heap_free[1] = 1'b1;
         awaited.delete();
         mismatches = 0;
         outstanding = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (awaited.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected response word: status %0d addr %0d order %0d",
                           rsp.status, rsp.addr, rsp.block_order);
            end else begin
               want = awaited.pop_front();
               if (want.status !== rsp.status || want.addr !== rsp.addr ||
                   want.block_order !== rsp.block_order) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected status %0d addr %0d order %0d, got %0d %0d %0d",
                              want.status, want.addr, want.block_order,
                              rsp.status, rsp.addr, rsp.block_order);
               end
            end
         end
         if (req.valid && req.ready) begin
            if (req.req_type == REQ_ALLOC) awaited.push_back(allocate_block(req.req_size));
            else awaited.push_back(release_block(req.free_addr));
         end
         outstanding = awaited.size();
      end
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the buddy allocator testbench: clock, reset, request and response
// traffic and the verdict. Depends on bba_pkg, the channels and bba_checker.
module tb_top;
   import bba_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   outstanding;
   int   send_idle = 6;
   int   recv_idle = 76;
   int   quiet_cycles = 0;
   logic             sent_kind [$];
   logic [DATA_W-1:0] live_blocks [$];
   logic [DATA_W-1:0] last_freed = 16'd1;

   bba_req_if req_chan ();
   bba_rsp_if rsp_chan ();

   buddy_block_allocator DUT (.clock(clock), .reset(reset),
                              .req_chan(req_chan), .rsp_chan(rsp_chan));

   bba_checker checker_i (.clock(clock), .reset(reset), .req(req_chan), .rsp(rsp_chan),
                          .mismatches(mismatches), .outstanding(outstanding));

   always #10 clock = ~clock;

   always @(negedge clock)
      rsp_chan.ready = ($urandom_range(99) >= recv_idle);

   // Learn which addresses are live so frees can target real blocks.
   always @(posedge clock) begin
      logic kind;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) sent_kind.push_back(req_chan.req_type);
         if (rsp_chan.valid && rsp_chan.ready && sent_kind.size() != 0) begin
            kind = sent_kind.pop_front();
            if (kind == REQ_ALLOC && rsp_chan.status == ST_OK)
               live_blocks.push_back(rsp_chan.addr);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(logic kind, logic [DATA_W-1:0] size, logic [DATA_W-1:0] a);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.req_type  = kind;
      req_chan.req_size  = size;
      req_chan.free_addr = a;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic alloc_bytes(logic [DATA_W-1:0] size);
      send_request(REQ_ALLOC, size, DATA_W'($urandom));
   endtask

   task automatic free_at(logic [DATA_W-1:0] a);
      send_request(REQ_FREE, DATA_W'($urandom), a);
   endtask

   task automatic random_request();
      int pick, idx;
      logic [DATA_W-1:0] a;
      pick = $urandom_range(99);
      if (pick < 45) begin
         // Mostly small blocks, now and then up to the whole heap.
         if ($urandom_range(9) == 0) alloc_bytes(DATA_W'($urandom));
         else alloc_bytes(DATA_W'($urandom_range(700)));
      end else if (pick < 85 && live_blocks.size() != 0) begin
         idx = $urandom_range(live_blocks.size() - 1);
         a = live_blocks[idx];
         live_blocks.delete(idx);
         last_freed = a;
         free_at(a);
      end else if (pick < 90) begin
         free_at(last_freed);
      end else if (pick < 93) begin
         free_at('0);
      end else begin
         free_at(DATA_W'($urandom));
      end
   endtask

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.req_type  = REQ_ALLOC;
      req_chan.req_size  = '0;
      req_chan.free_addr = '0;
      rsp_chan.ready     = 1'b0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Whole heap, exhaustion, bad frees, then the smallest and mid sizes.
      alloc_bytes(16'hFFFF);
      alloc_bytes(16'd0);
      free_at(16'd1);
      free_at(16'd1);
      free_at(16'd0);
      free_at(16'd2);
      free_at(16'd33);
      alloc_bytes(16'd0);
      alloc_bytes(16'd31);
      alloc_bytes(16'd32);
      alloc_bytes(16'd1000);
      free_at(16'd33);
      free_at(16'd1);
      free_at(16'd65);
      free_at(16'd1025);
      alloc_bytes(16'd32768);
      free_at(16'd1);
      alloc_bytes(16'd32767);
      alloc_bytes(16'd32767);
      alloc_bytes(16'd0);
      free_at(16'd32769);
      free_at(16'd1);
      free_at(16'hFFE1);

      for (int i = 0; i < 2000; i++) begin
         if (i == 700) begin
            send_idle = 76;
            recv_idle = 6;
         end else if (i == 1300) begin
            send_idle = 0;
            recv_idle = 0;
         end
         random_request();
      end
      req_chan.valid = 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### files.f
rtl/core/bba_pkg.sv
rtl/core/bba_req_if.sv
rtl/core/bba_rsp_if.sv
rtl/core/bba_ram.sv
rtl/core/bba_ctrl.sv
rtl/core/buddy_block_allocator.sv
tb/sv/bba_checker.sv
tb/sv/tb_top.sv
